>>> design/crc32bs_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32 byte stream package
// Polynomial, init and output XOR constants shared by the CRC byte stream unit.
// ----------------------------------------------------------------------------
package crc32bs_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT   = 32'h0000_0000;
  localparam logic [CRC_W-1:0] CRC_XOROUT = 32'hFFFF_FFFF;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;

endpackage

>>> design/crc32bs_fold.sv
// ----------------------------------------------------------------------------
// CRC-32 byte fold
// Folds one byte, LSB first, into a reflected CRC-32 remainder.
// ----------------------------------------------------------------------------
module crc32bs_fold (
  input  crc32bs_pkg::crc_t  rem_in,
  input  crc32bs_pkg::byte_t data_in,
  output crc32bs_pkg::crc_t  rem_out
);

  always_comb begin
    crc32bs_pkg::crc_t r;
    r = rem_in ^ {{(crc32bs_pkg::CRC_W - crc32bs_pkg::BYTE_W){1'b0}}, data_in};
    for (int k = 0; k < crc32bs_pkg::BYTE_W; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ crc32bs_pkg::CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    rem_out = r;
  end

endmodule

>>> design/crc32_byte_stream_unit.sv
// ----------------------------------------------------------------------------
// CRC-32 byte stream unit
// Reflected CRC-32 (init zero, output XOR all ones), one byte per item.
// Input reg, then result reg; the byte fold is a shallow XOR network.
// Throughput: one item per cycle while no result item waits on the output.
// Results appear only for last-byte or empty-message items.
// Reset (rst_n low, synchronous): remainder cleared, both stages empty.
// ----------------------------------------------------------------------------
module crc32_byte_stream_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  crc32bs_pkg::byte_t       in_data_byte,
  input  logic                     in_last_byte,
  input  logic                     in_empty_message,
  output logic                     out_valid,
  input  logic                     out_ready,
  output crc32bs_pkg::crc_t        out_crc_value
);

  // input stage
  logic               s1_valid_r;
  crc32bs_pkg::byte_t s1_data_r;
  logic               s1_last_r;
  logic               s1_empty_r;

  // state and result stage
  crc32bs_pkg::crc_t  rem_r;
  crc32bs_pkg::crc_t  rem_nxt;
  crc32bs_pkg::crc_t  fold_rem;
  logic               out_valid_r;
  crc32bs_pkg::crc_t  out_crc_r;
  crc32bs_pkg::crc_t  out_crc_nxt;

  logic s1_has_result;
  logic out_can_load;
  logic s1_adv;

  crc32bs_fold u_fold (
    .rem_in  (rem_r),
    .data_in (s1_data_r),
    .rem_out (fold_rem)
  );

  assign s1_has_result = s1_last_r | s1_empty_r;
  assign out_can_load  = ~out_valid_r | out_ready;
  // items that produce no result never wait on the output side
  assign s1_adv        = s1_valid_r & (~s1_has_result | out_can_load);
  assign in_ready      = ~s1_valid_r | s1_adv;

  always_comb begin
    if (s1_empty_r) begin
      rem_nxt     = crc32bs_pkg::CRC_INIT;
      out_crc_nxt = crc32bs_pkg::CRC_XOROUT;
    end else if (s1_last_r) begin
      rem_nxt     = crc32bs_pkg::CRC_INIT;
      out_crc_nxt = fold_rem ^ crc32bs_pkg::CRC_XOROUT;
    end else begin
      rem_nxt     = fold_rem;
      out_crc_nxt = fold_rem ^ crc32bs_pkg::CRC_XOROUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      rem_r       <= crc32bs_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        rem_r <= rem_nxt;
      end
      if (out_can_load) begin
        out_valid_r <= s1_adv & s1_has_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r  <= in_data_byte;
      s1_last_r  <= in_last_byte;
      s1_empty_r <= in_empty_message;
    end
    if (s1_adv && s1_has_result) begin
      out_crc_r <= out_crc_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  // a message end always clears the remainder
  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_has_result) |=> (rem_r == crc32bs_pkg::CRC_INIT))
    else $error("remainder not cleared after message end");

  // a middle byte is folded into the remainder
  a_fold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_has_result) |=> (rem_r == $past(fold_rem)))
    else $error("remainder not updated by middle byte");

  // a result-bearing item always lands in the result register
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_has_result) |=> (out_valid_r && out_crc_r == $past(out_crc_nxt)))
    else $error("result item lost");

  // an empty message always reports all ones
  a_empty_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_empty_r) |=> (out_crc_r == crc32bs_pkg::CRC_XOROUT))
    else $error("empty message result wrong");

endmodule

>>> tb/sv/tb_crc32_byte_stream_unit.sv
// ----------------------------------------------------------------------------
// CRC-32 byte stream unit testbench
// Feeds byte items with random sender gaps and receiver stalls. A local
// bit-serial CRC model computes each expected message CRC, and the monitor
// checks every result item against the oldest expected CRC, in order.
// ----------------------------------------------------------------------------
module tb_crc32_byte_stream_unit;

  typedef struct packed {
    crc32bs_pkg::byte_t data;
    logic               last;
    logic               empty;
  } byte_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  crc32bs_pkg::byte_t in_data_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               in_empty_message = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  crc32bs_pkg::crc_t  out_crc_value;

  byte_item_t        bytes_to_send[$];
  crc32bs_pkg::crc_t crc_expected[$];
  crc32bs_pkg::crc_t crc_remainder;

  int items_accepted = 0;
  int crcs_checked = 0;
  int empty_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet;

  crc32_byte_stream_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .in_empty_message (in_empty_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_crc_value    (out_crc_value)
  );

  always #5 clk = ~clk;

  // no random gaps on either side over this span of the run
  assign quiet = (items_accepted >= 400) && (items_accepted < 600);

  function automatic crc32bs_pkg::crc_t crc_fold_byte(input crc32bs_pkg::crc_t rem,
                                                      input crc32bs_pkg::byte_t b);
    crc32bs_pkg::crc_t r;
    r = rem ^ {{(crc32bs_pkg::CRC_W - crc32bs_pkg::BYTE_W){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) r = (r >> 1) ^ crc32bs_pkg::CRC_POLY;
      else      r = r >> 1;
    end
    return r;
  endfunction

  task automatic predict_crc(input byte_item_t it);
    if (it.empty) begin
      crc_remainder = crc32bs_pkg::CRC_INIT;
      crc_expected.push_back(crc32bs_pkg::CRC_XOROUT);
    end else begin
      crc_remainder = crc_fold_byte(crc_remainder, it.data);
      if (it.last) begin
        crc_expected.push_back(crc_remainder ^ crc32bs_pkg::CRC_XOROUT);
        crc_remainder = crc32bs_pkg::CRC_INIT;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_byte(input crc32bs_pkg::byte_t b, input logic last,
                            input logic empty);
    byte_item_t it;
    it.data  = b;
    it.last  = last;
    it.empty = empty;
    bytes_to_send.push_back(it);
  endtask

  task automatic queue_message(input int len, input bit terminate);
    for (int i = 0; i < len; i++)
      queue_byte(crc32bs_pkg::byte_t'($urandom_range(255)),
                 terminate && (i == len - 1), 1'b0);
  endtask

  // sender: a new item is chosen only once the current one is taken
  always @(posedge clk) begin
    byte_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (bytes_to_send.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
        it = bytes_to_send.pop_front();
        in_valid         <= 1'b1;
        in_data_byte     <= it.data;
        in_last_byte     <= it.last;
        in_empty_message <= it.empty;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && items_accepted >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 80;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  // monitor: check results first, then predict from the item taken this edge
  always @(posedge clk) begin
    crc32bs_pkg::crc_t exp_crc;
    byte_item_t        it;
    if (!rst_n) begin
      crc_remainder = crc32bs_pkg::CRC_INIT;
    end else begin
      if (out_valid && out_ready) begin
        if (crc_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result crc=%08h", out_crc_value));
        end else begin
          exp_crc = crc_expected.pop_front();
          if (out_crc_value !== exp_crc)
            report_mismatch($sformatf("crc_value got %08h want %08h",
                                      out_crc_value, exp_crc));
        end
        crcs_checked <= crcs_checked + 1;
      end
      if (in_valid && in_ready) begin
        it.data  = in_data_byte;
        it.last  = in_last_byte;
        it.empty = in_empty_message;
        predict_crc(it);
        items_accepted <= items_accepted + 1;
        if (it.empty) empty_seen <= empty_seen + 1;
      end
    end
  end

  initial begin
    string check_msg;
    int    n_rand;
    int    len;
    int    pick;
    check_msg = "123456789";

    // directed: empty-message forms, byte extremes, partial message discard
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'hFF, 1'b1, 1'b1);
    queue_byte(8'hA5, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < check_msg.len(); i++)
      queue_byte(crc32bs_pkg::byte_t'(check_msg[i]), i == check_msg.len() - 1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'h01, 1'b1, 1'b1);
    queue_byte(8'h55, 1'b0, 1'b0);
    queue_byte(8'hAA, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);

    // random: mostly complete messages, some empties and aborted messages
    n_rand = 0;
    while (n_rand < 800) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        queue_byte(crc32bs_pkg::byte_t'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        n_rand += 1;
      end else if (pick < 14) begin
        len = $urandom_range(1, 8);
        queue_message(len, 1'b0);
        queue_byte(crc32bs_pkg::byte_t'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        n_rand += len + 1;
      end else if (pick < 18) begin
        len = $urandom_range(32, 64);
        queue_message(len, 1'b1);
        n_rand += len;
      end else begin
        len = $urandom_range(1, 12);
        queue_message(len, 1'b1);
        n_rand += len;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_to_send.size() > 0 || in_valid) @(posedge clk);
    while (crc_expected.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d input items (%0d empty-message items), %0d CRC results checked",
             items_accepted, empty_seen, crcs_checked);
    $display("with random gaps, an 80-cycle receiver hold-off and a gap-free stretch");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout: %0d CRC results still expected", crc_expected.size());
    $display("simulation failed");
    $finish;
  end

endmodule
